// File: rtl/core/dis_pkg.sv
// ----------------------------------------------------------------------------
// dis_pkg: shared types for the descending index sort unit
// Beat structs for the input and result channels, plus the cell chain types.
// ----------------------------------------------------------------------------
package dis_pkg;

  localparam int unsigned KeyW         = 32;
  localparam int unsigned IdxW         = 6;
  localparam int unsigned MaxElemsDflt = 64;

  typedef struct packed {
    logic signed [KeyW-1:0] key_value;
    logic                   is_last;
  } in_beat_t;

  typedef struct packed {
    logic [IdxW-1:0] original_index;
    logic            last_rank;
    logic            overflowed;
  } res_beat_t;

  // Content of one sorter cell.
  typedef struct packed {
    logic                   valid;
    logic signed [KeyW-1:0] key;
    logic [IdxW-1:0]        idx;
  } cell_data_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic                   ins;
    logic                   pop;
    logic signed [KeyW-1:0] key;
    logic [IdxW-1:0]        idx;
  } cell_ctrl_t;

endpackage

// File: rtl/core/dis_cell.sv
// ----------------------------------------------------------------------------
// dis_cell: one cell of the insertion sort chain
// Holds one key/index pair; shifts down on insert, up on pop.
// ----------------------------------------------------------------------------
module dis_cell
  import dis_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  cell_data_t prev_i,        // neighbor toward the head
  input  logic       prev_before_i, // new key ranks before the head-side neighbor
  input  cell_data_t next_i,        // neighbor toward the tail
  output cell_data_t data_o,
  output logic       before_o
);

  cell_data_t data_q, data_d;

  // Strictly greater: an equal new key lands behind older ones (stable).
  assign before_o = !data_q.valid || (ctrl_i.key > data_q.key);
  assign data_o   = data_q;

  always_comb begin
    data_d = data_q;
    priority if (ctrl_i.pop) begin
      data_d = next_i;
    end else if (ctrl_i.ins && prev_before_i) begin
      data_d = prev_i;
    end else if (ctrl_i.ins && before_o) begin
      data_d.valid = 1'b1;
      data_d.key   = ctrl_i.key;
      data_d.idx   = ctrl_i.idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

endmodule

// File: rtl/core/descending_index_sort_unit.sv
// ----------------------------------------------------------------------------
// descending_index_sort_unit: stable argsort in descending key order
// Collects signed Q16.16 keys and emits their arrival indices, largest first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: a key beat is taken at a clock edge with start_i high and
//   busy_o low. Each beat carries key_value and is_last.
//   Every key is inserted into a chain of MaxElements cells in parallel:
//   all cells compare against the broadcast key and the lower part of the
//   chain shifts one cell down. Keys arriving while the chain is full are
//   dropped and flag the run as overflowed.
//   After the beat with is_last, busy_o goes high and the head cell pops one
//   result per cycle on res_o with res_valid_o high, until every stored key
//   is out. The first result appears the cycle right after the last key beat.
//   last_rank marks the final result; busy_o drops after it.
//   Keys load and results drain through the single insert/pop port of the
//   chain, so no new keys are taken while results drain.
//   Equal keys come out in arrival order.
//   Reset (rst_ni low, async) empties the chain and clears the overflow flag.
//   The receiver cannot stall: each result beat is valid for exactly one cycle.
// ----------------------------------------------------------------------------
module descending_index_sort_unit
  import dis_pkg::*;
#(
  parameter int unsigned MaxElements = MaxElemsDflt
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  input  in_beat_t  in_i,
  output logic      res_valid_o,
  output res_beat_t res_o
);

  localparam int unsigned CntW = $clog2(MaxElements + 1);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StEmit = 2'b10
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;

  logic        accept;
  logic        full;
  cell_ctrl_t  ctrl;
  cell_data_t  chain_data [MaxElements];
  logic        chain_before [MaxElements];
  logic [MaxElements-1:0] valid_vec;

  assign accept = start_i && (state_q == StIdle);
  assign full   = (count_q == CntW'(MaxElements));
  assign busy_o = (state_q == StEmit);

  // Broadcast insert/pop control. Index is the arrival position.
  always_comb begin
    ctrl.ins = accept && !full;
    ctrl.pop = (state_q == StEmit);
    ctrl.key = in_i.key_value;
    ctrl.idx = IdxW'(count_q);
  end

  // Cell chain: head is cell 0 (largest key).
  for (genvar g = 0; g < MaxElements; g++) begin : g_cell
    cell_data_t prev_data;
    cell_data_t next_data;
    logic       prev_before;

    if (g == 0) begin : g_head
      assign prev_data   = '0;
      assign prev_before = 1'b0;
    end else begin : g_body
      assign prev_data   = chain_data[g-1];
      assign prev_before = chain_before[g-1];
    end

    if (g == MaxElements - 1) begin : g_tail
      assign next_data = '0;
    end else begin : g_inner
      assign next_data = chain_data[g+1];
    end

    dis_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .prev_i        (prev_data),
      .prev_before_i (prev_before),
      .next_i        (next_data),
      .data_o        (chain_data[g]),
      .before_o      (chain_before[g])
    );

    assign valid_vec[g] = chain_data[g].valid;
  end

  // Sequencer: count keys on load, count down results on drain.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + CntW'(1);
          end
          if (in_i.is_last) begin
            state_d = StEmit;
          end
        end
      end
      StEmit: begin
        count_d = count_q - CntW'(1);
        if (count_q == CntW'(1)) begin
          state_d = StIdle;
          ovf_d   = 1'b0;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  // Result index comes straight from the head cell register; last_rank and overflowed come from the sequencer.
  assign res_valid_o          = (state_q == StEmit);
  assign res_o.original_index = chain_data[0].idx;
  assign res_o.last_rank      = (count_q == CntW'(1));
  assign res_o.overflowed     = ovf_q;

  // Occupied cells always match the element count.
  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == 32'(count_q))
    else $error("cell occupancy differs from element count");

  // A result always comes from a filled head cell.
  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> chain_data[0].valid)
    else $error("result popped from empty head cell");

  // The final rank ends the drain.
  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last_rank) |=> (!busy_o && count_q == '0 && !ovf_q))
    else $error("drain did not end after final rank");

  // A closing key beat starts the drain on the next cycle.
  a_last_starts_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.is_last) |=> res_valid_o)
    else $error("no result after closing key beat");

endmodule
